// ===== hw/rtl/ook_socket_frame_encoder_top_assert.svh =====
// Assertion macros for the OOK socket frame encoder.
`ifndef OOK_SOCKET_FRAME_ENCODER_TOP_ASSERT_SVH
`define OOK_SOCKET_FRAME_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTH
// Check an implication that must hold in the same cycle.
`define OOKSFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ooksfe assertion failed");
// Check an implication that must hold in the following cycle.
`define OOKSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ooksfe assertion failed");
`else
`define OOKSFE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OOKSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ooksfe_pkg.sv =====
// Package with the chip codes and frame constants of the OOK socket frame encoder.
`default_nettype none

package ooksfe_pkg;

    // Frame layout
    localparam int unsigned CODE_BITS         = 12;
    localparam int unsigned FRAME_WORDS       = 7;
    localparam int unsigned TRAILER_GAP_CHIPS = 14;
    localparam int unsigned IDX_W             = $clog2(FRAME_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(FRAME_WORDS - 1);

    // Chip patterns of one code bit, first chip in the top bit
    localparam logic [7:0] CODE_ONE  = 8'h88;
    localparam logic [7:0] CODE_ZERO = 8'h8E;

    // Word contents
    localparam logic [4:0]  WORD_CHIPS    = 5'd16;
    localparam logic [4:0]  TRAILER_CHIPS = 5'(1 + TRAILER_GAP_CHIPS);
    localparam logic [15:0] TRAILER_WORD  = 16'h8000;

    // Number of socket lines, socket A first
    localparam int unsigned SOCKETS = 5;

    typedef logic [CODE_BITS-1:0] t_code;

    // Chips for one code bit
    function automatic logic [7:0] code_chips(input logic b);
        return b ? CODE_ONE : CODE_ZERO;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ook_socket_frame_encoder_top.sv =====
// OOK socket frame encoder: command in, seven frame words of up to 16 chips out.
// Usage:
//   Slave stream takes one command per transaction: house address, socket
//   and on/off flag. The master stream gives the frame as seven words:
//   six words of two code bits each (16 chips, first chip in bit 15),
//   then a trailer word of one on chip and 14 off chips, marked by tlast.
// A command is first registered into the code register, and its first word
//   is then loaded from there into the output word register; the following
//   words come one per cycle while the receiver does not stall, set by the
//   single output word register that the frame shifts through.
// The next command is accepted in the cycle the trailer word is loaded,
//   so frames follow each other with no gap.
// Reset: synchronous, active low; clears the busy flag, the word counter
//   and the output valid flag. Payload registers are not reset.
// Receiver stall: while o_m_axis_tvalid is high and i_m_axis_tready is low,
//   the output word holds and the frame does not advance; the slave side
//   takes no new command until the trailer word has been loaded.
`default_nettype none

`include "ook_socket_frame_encoder_top_assert.svh"

module ook_socket_frame_encoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream: command
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [4:0] socket_address, [7:5] socket_select,
                                              // [8] switch_on, [15:9] zero
    // Master stream: frame words
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // [15:0] chip_word, [20:16] chip_count,
                                              // [23:21] zero
    output logic             o_m_axis_tlast   // last_word
);

    import ooksfe_pkg::*;

    logic [4:0]     w_addr;
    logic [2:0]     w_sel;
    logic           w_on;
    t_code          w_code;

    logic           r_busy,      n_busy;
    logic [IDX_W-1:0] r_idx,     n_idx;
    t_code          r_code,      n_code;
    logic           r_out_valid, n_out_valid;
    logic [15:0]    r_chip_word, n_chip_word;
    logic [4:0]     r_chip_count, n_chip_count;
    logic           r_last,      n_last;

    logic           w_advance;
    logic           w_in_ready;
    logic           w_in_xact;

    // Unpack the command
    assign w_addr = i_s_axis_tdata[4:0];
    assign w_sel  = i_s_axis_tdata[7:5];
    assign w_on   = i_s_axis_tdata[8];

    // Code bits in send order, first sent in the top bit
    always_comb begin
        w_code[CODE_BITS-1 -: 5] = w_addr;
        for (int s = 0; s < SOCKETS; s++) begin
            w_code[CODE_BITS-6-s] = (w_sel == 3'(s));
        end
        w_code[1] = w_on;
        w_code[0] = ~w_on;
    end

    // Handshake: output register moves when empty or taken
    assign w_advance  = !r_out_valid || i_m_axis_tready;
    assign w_in_ready = !r_busy || (w_advance && (r_idx == LAST_IDX));
    assign w_in_xact  = i_s_axis_tvalid && w_in_ready;

    // Next state of the frame shifter and output register
    always_comb begin
        n_busy       = r_busy;
        n_idx        = r_idx;
        n_code       = r_code;
        n_out_valid  = r_out_valid;
        n_chip_word  = r_chip_word;
        n_chip_count = r_chip_count;
        n_last       = r_last;

        if (w_advance) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                if (r_idx == LAST_IDX) begin
                    n_chip_word  = TRAILER_WORD;
                    n_chip_count = TRAILER_CHIPS;
                    n_last       = 1'b1;
                    n_busy       = 1'b0;
                end else begin
                    n_chip_word  = {code_chips(r_code[CODE_BITS-1]),
                                    code_chips(r_code[CODE_BITS-2])};
                    n_chip_count = WORD_CHIPS;
                    n_last       = 1'b0;
                    n_code       = r_code << 2;
                    n_idx        = r_idx + 1'b1;
                end
            end
        end

        // Load a new command
        if (w_in_xact) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_code = w_code;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_code       <= n_code;
        r_chip_word  <= n_chip_word;
        r_chip_count <= n_chip_count;
        r_last       <= n_last;
    end

    // Outputs
    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_chip_count, r_chip_word};
    assign o_m_axis_tlast  = r_last;

    // Assertions
    `OOKSFE_ASSERT_NOW(a_trailer_count, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata[20:16] == TRAILER_CHIPS)
    `OOKSFE_ASSERT_NEXT(a_frame_continues, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid)
    `OOKSFE_ASSERT_NEXT(a_cmd_starts_frame, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, r_busy && (r_idx == '0))
    `OOKSFE_ASSERT_NOW(a_idx_range, i_clk, i_rst_n,
        r_busy, r_idx <= LAST_IDX)

endmodule

`default_nettype wire
